/* hdl/lfr_pkg.sv */
package lfr_pkg;

    // Frame buffer geometry
    localparam int FRAME_BYTES = 13;
    localparam int HDR_LEN     = 4;
    // Only the header and the first four data bytes are ever looked at
    localparam int KEEP_BYTES  = 8;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 2);

    typedef logic [CNT_W-1:0] t_cnt;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HEADER_PATTERN = 3'd0;
    localparam t_cfg_idx CFG_TEMP_READ_ID   = 3'd1;
    localparam t_cfg_idx CFG_TEMP_WRITE_ID  = 3'd2;
    localparam t_cfg_idx CFG_STATUS_ID      = 3'd3;
    localparam t_cfg_idx CFG_SPEED_WRITE_ID = 3'd4;
    localparam t_cfg_idx CFG_CAN_BIT_MASK   = 3'd5;
    localparam t_cfg_idx CFG_LIN_BIT_MASK   = 3'd6;

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    // Result kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Network status codes
    localparam logic [1:0] ST_DOWN       = 2'd0;
    localparam logic [1:0] ST_OK         = 2'd1;
    localparam logic [1:0] ST_UNREPORTED = 2'd2;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Action queue between frame tracker and reply generator
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Work handed from the front to the back
    typedef struct packed {
        logic        is_read;
        logic [7:0]  reply;
        logic        temp_updated;
        logic [7:0]  received_temp;
        logic [1:0]  can_state;
        logic [1:0]  lin_state;
        logic [31:0] speed_raw;
    } t_action;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic        temp_updated;
        logic [7:0]  received_temp;
        logic [1:0]  can_state;
        logic [1:0]  lin_state;
        logic [31:0] speed_raw;
    } t_result;

    // Reflected CRC-8, init 0, over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] b);
        logic [7:0] crc;
        logic [7:0] d;
        logic       fb;
        crc = '0;
        d   = b;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ d[0];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

/* hdl/lfr_front.sv */
module lfr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte / idle events
    input  logic                          i_accept,
    input  logic                          i_cmd,
    input  logic [7:0]                    i_rx_byte,
    input  logic [7:0]                    i_reply_value,
    // configuration writes
    input  logic                          i_cfg_we,
    input  lfr_pkg::t_cfg_idx             i_cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // actions to the queue
    output logic                          o_act_push,
    output lfr_pkg::t_action              o_act
);

    // Configuration registers
    logic [23:0] r_header_pattern;
    logic [7:0]  r_temp_read_id;
    logic [7:0]  r_temp_write_id;
    logic [7:0]  r_status_id;
    logic [7:0]  r_speed_write_id;
    logic [7:0]  r_can_bit_mask;
    logic [7:0]  r_lin_bit_mask;

    // Frame and node state
    logic [7:0]       r_buf [lfr_pkg::KEEP_BYTES];
    logic [7:0]       n_buf [lfr_pkg::KEEP_BYTES];
    lfr_pkg::t_cnt    r_cnt, n_cnt;
    logic             r_hdr, n_hdr;
    logic             r_temp_flag, n_temp_flag;
    logic [7:0]       r_temp_value, n_temp_value;
    logic [1:0]       r_can_status, n_can_status;
    logic [1:0]       r_lin_status, n_lin_status;
    logic [31:0]      r_speed_word, n_speed_word;

    logic [7:0]       id;
    logic [7:0]       data0;

    assign id    = r_buf[3];
    assign data0 = r_buf[4];

    // Frame tracking and classification of idle events
    always_comb begin
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_hdr        = r_hdr;
        n_temp_flag  = r_temp_flag;
        n_temp_value = r_temp_value;
        n_can_status = r_can_status;
        n_lin_status = r_lin_status;
        n_speed_word = r_speed_word;
        o_act_push   = 1'b0;
        o_act        = '0;

        if (i_accept) begin
            if (i_cmd == lfr_pkg::CMD_BYTE) begin
                // store while inside the kept part of the buffer
                for (int i = 0; i < lfr_pkg::KEEP_BYTES; i++) begin
                    if (r_cnt == lfr_pkg::t_cnt'(i)) begin
                        n_buf[i] = i_rx_byte;
                    end
                end
                // saturate one past the buffer: frame too long
                if (r_cnt < lfr_pkg::t_cnt'(lfr_pkg::FRAME_BYTES + 1)) begin
                    n_cnt = r_cnt + lfr_pkg::t_cnt'(1);
                end
                // header check on arrival of the identifier byte
                if (r_cnt == lfr_pkg::t_cnt'(lfr_pkg::HDR_LEN - 1) &&
                    r_buf[0] == r_header_pattern[7:0] &&
                    r_buf[1] == r_header_pattern[15:8] &&
                    r_buf[2] == r_header_pattern[23:16]) begin
                    n_hdr = 1'b1;
                end
            end else if (r_hdr) begin
                // frame is consumed in all cases
                n_buf = '{default: '0};
                n_cnt = '0;
                n_hdr = 1'b0;
                if (r_cnt == lfr_pkg::t_cnt'(lfr_pkg::HDR_LEN)) begin
                    // header-only: temperature read request
                    if (id == r_temp_read_id) begin
                        o_act_push    = 1'b1;
                        o_act.is_read = 1'b1;
                        o_act.reply   = i_reply_value;
                    end
                end else if (r_cnt > lfr_pkg::t_cnt'(lfr_pkg::HDR_LEN) &&
                             r_cnt <= lfr_pkg::t_cnt'(lfr_pkg::FRAME_BYTES)) begin
                    // data frame; priority follows identifier order
                    if (id == r_temp_write_id) begin
                        n_temp_flag  = 1'b1;
                        n_temp_value = data0;
                    end else if (id == r_status_id) begin
                        n_can_status = ((data0 & r_can_bit_mask) != 8'd0) ?
                                       lfr_pkg::ST_OK : lfr_pkg::ST_DOWN;
                        n_lin_status = ((data0 & r_lin_bit_mask) != 8'd0) ?
                                       lfr_pkg::ST_OK : lfr_pkg::ST_DOWN;
                    end else if (id == r_speed_write_id) begin
                        n_speed_word = {r_buf[7], r_buf[6], r_buf[5], r_buf[4]};
                    end
                    o_act_push          = 1'b1;
                    o_act.is_read       = 1'b0;
                    o_act.temp_updated  = n_temp_flag;
                    o_act.received_temp = n_temp_value;
                    o_act.can_state     = n_can_status;
                    o_act.lin_state     = n_lin_status;
                    o_act.speed_raw     = n_speed_word;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf        <= '{default: '0};
            r_cnt        <= '0;
            r_hdr        <= 1'b0;
            r_temp_flag  <= 1'b0;
            r_temp_value <= '0;
            r_can_status <= lfr_pkg::ST_UNREPORTED;
            r_lin_status <= lfr_pkg::ST_UNREPORTED;
            r_speed_word <= '0;
        end else begin
            r_buf        <= n_buf;
            r_cnt        <= n_cnt;
            r_hdr        <= n_hdr;
            r_temp_flag  <= n_temp_flag;
            r_temp_value <= n_temp_value;
            r_can_status <= n_can_status;
            r_lin_status <= n_lin_status;
            r_speed_word <= n_speed_word;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pattern <= 24'h550000;
            r_temp_read_id   <= 8'd0;
            r_temp_write_id  <= 8'd1;
            r_status_id      <= 8'd2;
            r_speed_write_id <= 8'd3;
            r_can_bit_mask   <= 8'd1;
            r_lin_bit_mask   <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfr_pkg::CFG_HEADER_PATTERN: r_header_pattern <= i_cfg_data[23:0];
                lfr_pkg::CFG_TEMP_READ_ID:   r_temp_read_id   <= i_cfg_data[7:0];
                lfr_pkg::CFG_TEMP_WRITE_ID:  r_temp_write_id  <= i_cfg_data[7:0];
                lfr_pkg::CFG_STATUS_ID:      r_status_id      <= i_cfg_data[7:0];
                lfr_pkg::CFG_SPEED_WRITE_ID: r_speed_write_id <= i_cfg_data[7:0];
                lfr_pkg::CFG_CAN_BIT_MASK:   r_can_bit_mask   <= i_cfg_data[7:0];
                lfr_pkg::CFG_LIN_BIT_MASK:   r_lin_bit_mask   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

/* hdl/lfr_queue.sv */
module lfr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lfr_pkg::t_action i_data,
    output logic             o_full,
    input  logic             i_pop,
    output lfr_pkg::t_action o_head,
    output logic             o_empty
);

    lfr_pkg::t_action                r_mem [lfr_pkg::QUEUE_DEPTH];
    logic [lfr_pkg::QPTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [lfr_pkg::QCNT_W-1:0]      r_count;
    logic                            do_push, do_pop;

    assign o_full  = (r_count == lfr_pkg::QCNT_W'(lfr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage (depth is a power of two, pointers wrap naturally)
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + lfr_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + lfr_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + lfr_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - lfr_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/lfr_back.sv */
module lfr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // action queue side
    input  lfr_pkg::t_action i_head,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    // result side
    output logic             o_valid,
    output lfr_pkg::t_result o_res,
    input  logic             i_pop
);

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_valid, n_valid;
    lfr_pkg::t_result r_res, n_res;
    logic             load_ok;

    assign load_ok = !r_valid || i_pop;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Result sequencing: read request gives reply then CRC, data frame one report
    always_comb begin
        n_phase = r_phase;
        n_valid = r_valid && !i_pop;
        n_res   = r_res;
        o_q_pop = 1'b0;
        if (load_ok && !i_q_empty) begin
            n_valid = 1'b1;
            n_res   = '0;
            if (i_head.is_read) begin
                n_res.kind = lfr_pkg::KIND_TX;
                case (r_phase)
                    PH_FIRST: begin
                        n_res.tx_byte = i_head.reply;
                        n_res.last    = 1'b0;
                        n_phase       = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_res.tx_byte = lfr_pkg::crc8_byte(i_head.reply);
                        n_res.last    = 1'b1;
                        n_phase       = PH_FIRST;
                        o_q_pop       = 1'b1;
                    end
                    default: n_phase = PH_FIRST;
                endcase
            end else begin
                n_res.kind          = lfr_pkg::KIND_REPORT;
                n_res.last          = 1'b1;
                n_res.temp_updated  = i_head.temp_updated;
                n_res.received_temp = i_head.received_temp;
                n_res.can_state     = i_head.can_state;
                n_res.lin_state     = i_head.lin_state;
                n_res.speed_raw     = i_head.speed_raw;
                o_q_pop             = 1'b1;
            end
        end
    end

    // Phase and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
        r_res <= n_res;
    end

endmodule

/* hdl/lin_frame_responder.sv */
// A line-idle event that triggers a reply is first written into the action queue;
//   its first result is then loaded from the queue head into the output register.
// Throughput: one input item per cycle until the two-entry action queue fills;
//   a read request gives two results (reply byte, then CRC byte), a report one.
// Reset: synchronous, active low; restores frame, status and config defaults
//   and empties the action queue and the output register.
module lin_frame_responder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           push,
    output logic                           full,
    input  logic                           i_cmd,
    input  logic [7:0]                     i_rx_byte,
    input  logic [7:0]                     i_reply_value,
    // result items
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_kind,
    output logic [7:0]                     o_tx_byte,
    output logic                           o_last,
    output logic                           o_temp_updated,
    output logic [7:0]                     o_received_temp,
    output logic [1:0]                     o_can_state,
    output logic [1:0]                     o_lin_state,
    output logic [31:0]                    o_speed_raw,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  lfr_pkg::t_cfg_idx              i_cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic             in_xfer;
    logic             act_push;
    lfr_pkg::t_action act;
    lfr_pkg::t_action q_head;
    logic             q_full, q_empty, q_pop;
    logic             res_valid;
    lfr_pkg::t_result res;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign in_xfer     = push && !q_full;

    lfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_cmd         (i_cmd),
        .i_rx_byte     (i_rx_byte),
        .i_reply_value (i_reply_value),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_act_push    (act_push),
        .o_act         (act)
    );

    lfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (act_push),
        .i_data  (act),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    lfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_valid   (res_valid),
        .o_res     (res),
        .i_pop     (pop)
    );

    // Result ports
    assign empty           = !res_valid;
    assign o_kind          = res.kind;
    assign o_tx_byte       = res.tx_byte;
    assign o_last          = res.last;
    assign o_temp_updated  = res.temp_updated;
    assign o_received_temp = res.received_temp;
    assign o_can_state     = res.can_state;
    assign o_lin_state     = res.lin_state;
    assign o_speed_raw     = res.speed_raw;

endmodule

/* hdl/lfr_checker.sv */
module lfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_kind,
    input logic [7:0]  o_tx_byte,
    input logic        o_last,
    input logic        o_temp_updated,
    input logic [7:0]  o_received_temp,
    input logic [1:0]  o_can_state,
    input logic [1:0]  o_lin_state,
    input logic [31:0] o_speed_raw
);

    // A waiting result holds until transferred
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_tx_byte) && $stable(o_kind) &&
                              $stable(o_last)))
        else $error("result changed while waiting");

    // Transmit results carry no status copies
    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == lfr_pkg::KIND_TX) |->
        (!o_temp_updated && o_received_temp == 8'd0 && o_can_state == 2'd0 &&
         o_lin_state == 2'd0 && o_speed_raw == 32'd0))
        else $error("transmit result with status fields set");

    // A status report is a single, final result with no transmit byte
    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == lfr_pkg::KIND_REPORT) |-> (o_last && o_tx_byte == 8'd0))
        else $error("malformed status report");

    // A reply byte is followed by its CRC byte as the next result
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> (!empty && o_kind == lfr_pkg::KIND_TX && o_last))
        else $error("reply byte not followed by CRC");

endmodule

bind lin_frame_responder lfr_checker u_lfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_kind          (o_kind),
    .o_tx_byte       (o_tx_byte),
    .o_last          (o_last),
    .o_temp_updated  (o_temp_updated),
    .o_received_temp (o_received_temp),
    .o_can_state     (o_can_state),
    .o_lin_state     (o_lin_state),
    .o_speed_raw     (o_speed_raw)
);

/* verif/lfr_reply_pkg.sv */
package lfr_reply_pkg;

    // Tracks the slave's frame state and the replies it owes
    class frame_reply_tracker;

        // register copies
        logic [23:0] hdr_pattern;
        logic [7:0]  rd_id;
        logic [7:0]  wr_id;
        logic [7:0]  st_id;
        logic [7:0]  spd_id;
        logic [7:0]  can_mask;
        logic [7:0]  lin_mask;

        // frame and status state
        logic [7:0]  frame [lfr_pkg::FRAME_BYTES];
        int unsigned fill;
        bit          hdr_ok;
        bit          temp_seen;
        logic [7:0]  temp_byte;
        logic [1:0]  can_st;
        logic [1:0]  lin_st;
        logic [31:0] speed;

        lfr_pkg::t_result replies_due [$];
        int unsigned      bad_fields;

        function new();
            hdr_pattern = 24'h550000;
            rd_id       = 8'd0;
            wr_id       = 8'd1;
            st_id       = 8'd2;
            spd_id      = 8'd3;
            can_mask    = 8'd1;
            lin_mask    = 8'd2;
            clear_frame();
            temp_seen   = 1'b0;
            temp_byte   = 8'd0;
            can_st      = lfr_pkg::ST_UNREPORTED;
            lin_st      = lfr_pkg::ST_UNREPORTED;
            speed       = 32'd0;
            bad_fields  = 0;
        endfunction

        function void clear_frame();
            hdr_ok = 1'b0;
            fill   = 0;
            foreach (frame[k]) frame[k] = 8'd0;
        endfunction

        // Reflected CRC-8, poly 0x8C, init 0
        function logic [7:0] crc8_reflected(logic [7:0] b);
            logic [7:0] crc;
            logic       fb;
            crc = 8'd0;
            for (int k = 0; k < 8; k++) begin
                fb  = crc[0] ^ b[k];
                crc = crc >> 1;
                if (fb) crc = crc ^ 8'h8C;
            end
            return crc;
        endfunction

        function void set_reg(lfr_pkg::t_cfg_idx idx, logic [lfr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lfr_pkg::CFG_HEADER_PATTERN: hdr_pattern = data[23:0];
                lfr_pkg::CFG_TEMP_READ_ID:   rd_id       = data[7:0];
                lfr_pkg::CFG_TEMP_WRITE_ID:  wr_id       = data[7:0];
                lfr_pkg::CFG_STATUS_ID:      st_id       = data[7:0];
                lfr_pkg::CFG_SPEED_WRITE_ID: spd_id      = data[7:0];
                lfr_pkg::CFG_CAN_BIT_MASK:   can_mask    = data[7:0];
                lfr_pkg::CFG_LIN_BIT_MASK:   lin_mask    = data[7:0];
                default: ;
            endcase
        endfunction

        // Note one input transfer and queue the replies it causes
        function void note_item(logic cmd, logic [7:0] rx, logic [7:0] reply);
            logic [7:0]       id;
            logic [7:0]       d;
            lfr_pkg::t_result r;
            if (cmd == lfr_pkg::CMD_BYTE) begin
                if (fill < lfr_pkg::FRAME_BYTES) frame[fill] = rx;
                if (fill < lfr_pkg::FRAME_BYTES + 1) fill++;
                if (fill == lfr_pkg::HDR_LEN && {frame[2], frame[1], frame[0]} == hdr_pattern)
                    hdr_ok = 1'b1;
                return;
            end
            // line idle: only acts on a recognized header
            if (!hdr_ok) return;
            id = frame[3];
            d  = frame[4];
            r  = '0;
            if (fill == lfr_pkg::HDR_LEN) begin
                clear_frame();
                if (id == rd_id) begin
                    r.kind    = lfr_pkg::KIND_TX;
                    r.tx_byte = reply;
                    replies_due.push_back(r);
                    r.tx_byte = crc8_reflected(reply);
                    r.last    = 1'b1;
                    replies_due.push_back(r);
                end
            end else if (fill <= lfr_pkg::FRAME_BYTES) begin
                // write id wins over status, status over speed
                if (id == wr_id) begin
                    temp_seen = 1'b1;
                    temp_byte = d;
                end else if (id == st_id) begin
                    can_st = ((d & can_mask) != 0) ? lfr_pkg::ST_OK : lfr_pkg::ST_DOWN;
                    lin_st = ((d & lin_mask) != 0) ? lfr_pkg::ST_OK : lfr_pkg::ST_DOWN;
                end else if (id == spd_id) begin
                    speed = {frame[7], frame[6], frame[5], frame[4]};
                end
                clear_frame();
                r.kind          = lfr_pkg::KIND_REPORT;
                r.last          = 1'b1;
                r.temp_updated  = temp_seen;
                r.received_temp = temp_byte;
                r.can_state     = can_st;
                r.lin_state     = lin_st;
                r.speed_raw     = speed;
                replies_due.push_back(r);
            end else begin
                // too long: dropped
                clear_frame();
            end
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            bad_fields++;
            if (bad_fields <= 10)
                $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
        endfunction

        // Compare one result transfer with the oldest expected reply
        function void check_result(lfr_pkg::t_result got);
            lfr_pkg::t_result want;
            if (replies_due.size() == 0) begin
                bad_fields++;
                if (bad_fields <= 10)
                    $display("unexpected result: kind %0d tx_byte 0x%0h", got.kind, got.tx_byte);
                return;
            end
            want = replies_due.pop_front();
            if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
            if (got.tx_byte !== want.tx_byte) flag("tx_byte", want.tx_byte, got.tx_byte);
            if (got.last !== want.last) flag("last", want.last, got.last);
            if (got.temp_updated !== want.temp_updated)
                flag("temp_updated", want.temp_updated, got.temp_updated);
            if (got.received_temp !== want.received_temp)
                flag("received_temp", want.received_temp, got.received_temp);
            if (got.can_state !== want.can_state)
                flag("can_state", want.can_state, got.can_state);
            if (got.lin_state !== want.lin_state)
                flag("lin_state", want.lin_state, got.lin_state);
            if (got.speed_raw !== want.speed_raw)
                flag("speed_raw", want.speed_raw, got.speed_raw);
        endfunction

    endclass

endpackage

/* verif/tb_top.sv */
module tb_top;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic                           i_cmd = lfr_pkg::CMD_BYTE;
    logic [7:0]                     i_rx_byte = 8'd0;
    logic [7:0]                     i_reply_value = 8'd0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           o_kind;
    logic [7:0]                     o_tx_byte;
    logic                           o_last;
    logic                           o_temp_updated;
    logic [7:0]                     o_received_temp;
    logic [1:0]                     o_can_state;
    logic [1:0]                     o_lin_state;
    logic [31:0]                    o_speed_raw;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    lfr_pkg::t_cfg_idx              i_cfg_index = lfr_pkg::CFG_HEADER_PATTERN;
    logic [lfr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    lfr_reply_pkg::frame_reply_tracker tracker;
    int unsigned                       items_sent = 0;
    int unsigned                       gap_pct = 0;
    int unsigned                       stall_pct = 0;

    lin_frame_responder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_rx_byte       (i_rx_byte),
        .i_reply_value   (i_reply_value),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_temp_updated  (o_temp_updated),
        .o_received_temp (o_received_temp),
        .o_can_state     (o_can_state),
        .o_lin_state     (o_lin_state),
        .o_speed_raw     (o_speed_raw),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 unit clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    // One input transfer, with an optional idle burst ahead of it
    task automatic send_item(input logic cmd, input logic [7:0] rx, input logic [7:0] reply);
        int gap;
        @(negedge i_clk);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            gap  = $urandom_range(1, 14);
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push          = 1'b1;
        i_cmd         = cmd;
        i_rx_byte     = rx;
        i_reply_value = reply;
        do @(posedge i_clk); while (full);
        tracker.note_item(cmd, rx, reply);
        items_sent++;
    endtask

    // Header from the current pattern, id, data bytes, then line idle.
    // Noisy frames add idles that the block ignores (empty buffer or short header).
    task automatic send_frame(input logic [7:0] id, input int ndata, input logic [31:0] data,
                              input logic [7:0] reply, input bit noisy);
        if (noisy && $urandom_range(7) == 0)
            send_item(lfr_pkg::CMD_IDLE, rand8(), rand8());
        for (int k = 0; k < 3; k++) begin
            send_item(lfr_pkg::CMD_BYTE, tracker.hdr_pattern[8*k +: 8], rand8());
            if (noisy && $urandom_range(9) == 0)
                send_item(lfr_pkg::CMD_IDLE, rand8(), rand8());
        end
        send_item(lfr_pkg::CMD_BYTE, id, rand8());
        for (int k = 0; k < ndata; k++)
            send_item(lfr_pkg::CMD_BYTE, (k < 4) ? data[8*k +: 8] : rand8(), rand8());
        send_item(lfr_pkg::CMD_IDLE, rand8(), reply);
        // a second idle finds no header
        if (noisy && $urandom_range(6) == 0)
            send_item(lfr_pkg::CMD_IDLE, rand8(), rand8());
    endtask

    task automatic send_random_frame();
        logic [7:0] id;
        int         ndata;
        int         pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1:    id = tracker.rd_id;
            2, 3:    id = tracker.wr_id;
            4, 5:    id = tracker.st_id;
            6, 7:    id = tracker.spd_id;
            default: id = rand8();
        endcase
        pick = $urandom_range(99);
        if (pick < 25)      ndata = 0;
        else if (pick < 75) ndata = $urandom_range(1, 5);
        else if (pick < 90) ndata = $urandom_range(6, 9);
        else                ndata = $urandom_range(10, 12);  // overflows the buffer
        send_frame(id, ndata, $urandom, rand8(), 1'b1);
    endtask

    // Wait until every reply is out, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        while (tracker.replies_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input lfr_pkg::t_cfg_idx idx,
                             input logic [lfr_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Upper data bits of the byte registers carry junk on purpose
    task automatic load_config(input logic [23:0] hdr, input logic [7:0] rd,
                               input logic [7:0] wr, input logic [7:0] st,
                               input logic [7:0] spd, input logic [7:0] cm,
                               input logic [7:0] lm);
        drain();
        write_reg(lfr_pkg::CFG_HEADER_PATTERN, hdr);
        write_reg(lfr_pkg::CFG_TEMP_READ_ID,   {16'($urandom), rd});
        write_reg(lfr_pkg::CFG_TEMP_WRITE_ID,  {16'($urandom), wr});
        write_reg(lfr_pkg::CFG_STATUS_ID,      {16'($urandom), st});
        write_reg(lfr_pkg::CFG_SPEED_WRITE_ID, {16'($urandom), spd});
        write_reg(lfr_pkg::CFG_CAN_BIT_MASK,   {16'($urandom), cm});
        write_reg(lfr_pkg::CFG_LIN_BIT_MASK,   {16'($urandom), lm});
    endtask

    task automatic load_random_config();
        logic [7:0] idv [4];
        foreach (idv[k]) idv[k] = rand8();
        // shared ids exercise the priority order
        if ($urandom_range(2) == 0) idv[$urandom_range(1, 3)] = idv[$urandom_range(0, 3)];
        load_config(24'($urandom), idv[0], idv[1], idv[2], idv[3], rand8(), rand8());
    endtask

    // Random frames; idle rates re-picked now and then, none when quiet
    task automatic run_frames(input int unsigned count, input bit quiet);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target) begin
            if (quiet) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if ($urandom_range(7) == 0) begin
                gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 60);
                stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 60);
            end
            send_random_frame();
        end
    endtask

    // Result side: random stalls with pop held low
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                pop = 1'b0;
                stall--;
            end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                pop   = 1'b0;
                stall = $urandom_range(0, 13);
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Check each result transfer
    always @(posedge i_clk) begin : result_check
        lfr_pkg::t_result got;
        if (i_rst_n && pop && !empty) begin
            got = {o_kind, o_tx_byte, o_last, o_temp_updated, o_received_temp,
                   o_can_state, o_lin_state, o_speed_raw};
            tracker.check_result(got);
        end
    end

    initial begin
        tracker = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset config: header 00 00 55, ids 0..3
        send_item(lfr_pkg::CMD_IDLE, 8'hFF, 8'h00);             // idle with no header
        send_frame(tracker.rd_id, 0, 32'd0, 8'hFF, 1'b0);       // read, reply FF
        send_frame(tracker.rd_id, 0, 32'd0, 8'h00, 1'b0);       // read, reply 00
        send_item(lfr_pkg::CMD_IDLE, 8'h00, 8'h5A);             // repeated idle
        send_frame(tracker.wr_id, 1, 32'h0000_00FF, 8'h00, 1'b0);
        send_frame(tracker.spd_id, 2, 32'h0000_BEEF, 8'h00, 1'b0); // short speed word

        gap_pct   = 30;
        stall_pct = 30;
        run_frames(250, 1'b0);

        // all-zero and all-one settings
        load_config(24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_frames(250, 1'b0);
        load_config(24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_frames(250, 1'b0);

        for (int p = 0; p < 4; p++) begin
            load_random_config();
            run_frames(250, 1'b0);
        end

        // back to reset values, no idling from here on
        gap_pct   = 0;
        stall_pct = 0;
        load_config(24'h550000, 8'h00, 8'h01, 8'h02, 8'h03, 8'h01, 8'h02);
        run_frames(250, 1'b1);

        // bad header byte: the buffer never resyncs, nothing may come out
        send_item(lfr_pkg::CMD_BYTE, tracker.hdr_pattern[7:0] ^ 8'h80, rand8());
        repeat (24)
            send_item(($urandom_range(3) == 0) ? lfr_pkg::CMD_IDLE : lfr_pkg::CMD_BYTE,
                      rand8(), rand8());

        drain();
        repeat (20) @(posedge i_clk);
        if (tracker.bad_fields == 0 && tracker.replies_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20 * 800000);
        $display("FAIL");
        $finish;
    end

endmodule
